// ===== rtl/spg_pkg.sv =====
// Shared types and codes for the step pulse generator.
`timescale 1ns / 1ps

package spg_pkg;

  localparam int DATA_W = 32;

  localparam logic [2:0] OP_TICK           = 3'd0;
  localparam logic [2:0] OP_START_COUNTED  = 3'd1;
  localparam logic [2:0] OP_START_VELOCITY = 3'd2;
  localparam logic [2:0] OP_SET_RATE       = 3'd3;
  localparam logic [2:0] OP_STOP           = 3'd4;

  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_COUNTED  = 2'd1;
  localparam logic [1:0] MODE_VELOCITY = 2'd2;

  localparam logic REG_HALF_PERIOD  = 1'b0;
  localparam logic REG_PULSE_TARGET = 1'b1;

  typedef struct packed {
    logic              write;
    logic              index;
    logic [DATA_W-1:0] data;
  } cfg_t;

  typedef struct packed {
    logic              pin_level;
    logic [DATA_W-1:0] pulses_emitted;
    logic              move_done;
    logic              active;
  } result_t;

endpackage

// ===== rtl/spg_core.sv =====
// Step timer state, configuration registers and per-request update.
`timescale 1ns / 1ps

module spg_core import spg_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          push,
  input  logic [2:0]    opcode,
  input  logic [31:0]   phase_increment,
  output result_t       result
);

  logic [31:0]           half_period;
  logic [30:0]           pulse_target;
  logic [1:0]            run_mode, run_mode_next;
  logic                  pin_state, pin_state_next;
  logic [31:0]           tick_counter, tick_counter_next;
  logic [31:0]           transition_count, transition_count_next;
  logic [PHASE_BITS-1:0] phase_accumulator, phase_accumulator_next;
  logic [PHASE_BITS-1:0] current_increment, current_increment_next;
  logic [COUNT_BITS-1:0] emitted_count, emitted_count_next;
  logic                  done_flag, done_flag_next;

  logic [PHASE_BITS-1:0] inc;
  logic [31:0]           goal;
  logic [31:0]           hp;
  logic [31:0]           tick_inc;
  logic [PHASE_BITS:0]   sum;

  assign inc  = PHASE_BITS'(phase_increment);
  assign goal = {pulse_target, 1'b0};
  assign hp   = (half_period == '0) ? 32'd1 : half_period;

  always_comb begin
    run_mode_next          = run_mode;
    pin_state_next         = pin_state;
    tick_counter_next      = tick_counter;
    transition_count_next  = transition_count;
    phase_accumulator_next = phase_accumulator;
    current_increment_next = current_increment;
    emitted_count_next     = emitted_count;
    done_flag_next         = done_flag;
    tick_inc               = '0;
    sum                    = '0;

    case (opcode)
      OP_START_COUNTED: begin
        run_mode_next         = MODE_COUNTED;
        pin_state_next        = 1'b0;
        tick_counter_next     = '0;
        transition_count_next = '0;
        emitted_count_next    = '0;
        done_flag_next        = 1'b0;
      end
      OP_START_VELOCITY: begin
        run_mode_next          = MODE_VELOCITY;
        current_increment_next = inc;
        phase_accumulator_next = '0;
        pin_state_next         = 1'b0;
        emitted_count_next     = '0;
        done_flag_next         = 1'b0;
      end
      OP_SET_RATE: begin
        if (run_mode == MODE_VELOCITY) begin
          current_increment_next = inc;
        end
      end
      OP_STOP: begin
        run_mode_next          = MODE_IDLE;
        pin_state_next         = 1'b0;
        phase_accumulator_next = '0;
        done_flag_next         = 1'b0;
      end
      default: begin
      end
    endcase

    if (run_mode_next == MODE_COUNTED) begin
      if (transition_count_next < goal) begin
        tick_inc = tick_counter_next + 32'd1;
        if (tick_inc >= hp) begin
          tick_counter_next     = '0;
          pin_state_next        = ~pin_state_next;
          transition_count_next = transition_count_next + 32'd1;
          if (!pin_state_next) begin
            emitted_count_next = emitted_count_next + 1'b1;
          end
        end else begin
          tick_counter_next = tick_inc;
        end
      end
      if (transition_count_next >= goal) begin
        done_flag_next = 1'b1;
        run_mode_next  = MODE_IDLE;
      end
    end else if (run_mode_next == MODE_VELOCITY) begin
      sum = {1'b0, phase_accumulator_next} + {1'b0, current_increment_next};
      if (sum[PHASE_BITS]) begin
        emitted_count_next = emitted_count_next + 1'b1;
      end
      phase_accumulator_next = sum[PHASE_BITS-1:0];
      pin_state_next         = sum[PHASE_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period  <= 32'd1;
      pulse_target <= '0;
    end else if (cfg.write) begin
      case (cfg.index)
        REG_HALF_PERIOD:  half_period  <= cfg.data;
        REG_PULSE_TARGET: pulse_target <= cfg.data[30:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode          <= MODE_IDLE;
      pin_state         <= 1'b0;
      tick_counter      <= '0;
      transition_count  <= '0;
      phase_accumulator <= '0;
      current_increment <= '0;
      emitted_count     <= '0;
      done_flag         <= 1'b0;
    end else if (push) begin
      run_mode          <= run_mode_next;
      pin_state         <= pin_state_next;
      tick_counter      <= tick_counter_next;
      transition_count  <= transition_count_next;
      phase_accumulator <= phase_accumulator_next;
      current_increment <= current_increment_next;
      emitted_count     <= emitted_count_next;
      done_flag         <= done_flag_next;
    end
  end

  assign result.pin_level      = pin_state_next;
  assign result.pulses_emitted = DATA_W'(emitted_count_next);
  assign result.move_done      = done_flag_next;
  assign result.active         = (run_mode_next != MODE_IDLE);

endmodule

// ===== rtl/spg_out_buf.sv =====
// Result register with a skid entry behind it.
`timescale 1ns / 1ps

module spg_out_buf import spg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;
  logic    main_free;

  assign main_free = !main_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

endmodule

// ===== rtl/step_pulse_generator.sv =====
// Top level of the single-channel step pulse generator.
//
//   channel  signals                                   direction
//   in       in_valid, in_stall, opcode, phase_increment  request in
//   out      out_valid, out_stall, pin_level, pulses_emitted,
//            move_done, active                          result out
//   cfg      cfg_write, cfg_index, cfg_data             register write
//
// One request per cycle unless in_stall is high; results are registered.
// The timer state and the pulse counter update in the cycle a request is taken.
// A two-entry output buffer keeps input flowing while one result waits.
// Reset is synchronous; it clears the timer state and restores the registers.
`timescale 1ns / 1ps

module step_pulse_generator import spg_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [31:0] phase_increment,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pin_level,
  output logic [31:0] pulses_emitted,
  output logic        move_done,
  output logic        active
);

  cfg_t    cfg;
  logic    push;
  logic    full;
  result_t core_result;
  result_t out_data;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign in_stall = full;
  assign push     = in_valid && !full;

  spg_core #(
    .PHASE_BITS(PHASE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .push            (push),
    .opcode          (opcode),
    .phase_increment (phase_increment),
    .result          (core_result)
  );

  spg_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (core_result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign pin_level      = out_data.pin_level;
  assign pulses_emitted = out_data.pulses_emitted;
  assign move_done      = out_data.move_done;
  assign active         = out_data.active;

  a_stall_needs_result: assert property (@(posedge clk) in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_done_is_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && move_done) |-> !active)
    else $error("finished move still reported active");

  a_reset_empties: assert property (@(posedge clk) rst |=> (!out_valid && !in_stall))
    else $error("output buffer not empty after reset");

  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

endmodule
